// ===== design/itdt_pkg.sv =====
// ---------------------------------------------------------------------------
// itdt_pkg: shared types and constants for integer_to_decimal_text
// Value width, digit counts, conversion step sizing, ASCII codes, queue
// entry layout and state machine encodings.
// ---------------------------------------------------------------------------
package itdt_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int digits_for(int bits);
    longint unsigned lim;
    longint unsigned p;
    int n;
    lim = 64'd1 << (bits - 1);
    p = 64'd10;
    n = 1;
    for (int k = 0; k < 19; k++) begin
      if (p <= lim) n++;
      if (k < 18) p = p * 64'd10;
    end
    return n;
  endfunction

  localparam int DIGITS        = digits_for(VALUE_WIDTH);
  localparam int DIGIT_IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_WIDTH     = STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADJ   = 4'd3;

  typedef struct packed {
    logic                         neg;
    logic [DIGITS-1:0][3:0]       digits;
    logic [DIGIT_IDX_W-1:0]       top;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_DONE
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } bk_state_t;

endpackage

// ===== design/itdt_front.sv =====
// ---------------------------------------------------------------------------
// itdt_front: input side of integer_to_decimal_text
// Accepts a value, splits off the sign, converts the magnitude to BCD four
// bits per cycle (shift-add-3) and pushes digits and top index to the queue.
// ---------------------------------------------------------------------------
module itdt_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [itdt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                   q_push,
  output itdt_pkg::entry_t                       q_data,
  input  itdt_pkg::q_status_t                    q_status
);

  localparam int W = itdt_pkg::VALUE_WIDTH;

  itdt_pkg::fe_state_t state_r, state_nxt;

  logic [itdt_pkg::PAD_WIDTH-1:0]          mag_r, mag_nxt;
  logic [itdt_pkg::DIGITS-1:0][3:0]        bcd_r, bcd_nxt;
  logic [itdt_pkg::STEP_CNT_W-1:0]         cnt_r;
  logic                                    neg_r;
  logic [W-1:0]                            raw;
  logic [W-1:0]                            in_mag;
  logic [itdt_pkg::DIGIT_IDX_W-1:0]        top;
  logic                                    accept;

  assign raw    = $unsigned(in_value);
  assign in_mag = raw[W-1] ? (~raw + W'(1)) : raw;
  assign accept = in_valid && !in_stall;

  // Four dependent shift-add-3 steps per cycle.
  always_comb begin
    logic [itdt_pkg::DIGITS-1:0][3:0] b;
    logic [itdt_pkg::PAD_WIDTH-1:0]   m;
    b = bcd_r;
    m = mag_r;
    for (int s = 0; s < itdt_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < itdt_pkg::DIGITS; d++) begin
        if (b[d] >= itdt_pkg::DABBLE_LIMIT) b[d] = b[d] + itdt_pkg::DABBLE_ADJ;
      end
      {b, m} = {b, m} << 1;
    end
    bcd_nxt = b;
    mag_nxt = m;
  end

  // Index of the most significant nonzero digit; zero keeps index 0.
  always_comb begin
    top = '0;
    for (int d = 0; d < itdt_pkg::DIGITS; d++) begin
      if (bcd_r[d] != 4'd0) top = itdt_pkg::DIGIT_IDX_W'(d);
    end
  end

  assign q_data = '{neg: neg_r, digits: bcd_r, top: top};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itdt_pkg::FE_IDLE: begin
        if (in_valid) state_nxt = itdt_pkg::FE_CONV;
      end
      itdt_pkg::FE_CONV: begin
        if (cnt_r == '0) state_nxt = itdt_pkg::FE_DONE;
      end
      itdt_pkg::FE_DONE: begin
        if (!q_status.full) state_nxt = in_valid ? itdt_pkg::FE_CONV : itdt_pkg::FE_IDLE;
      end
      default: state_nxt = itdt_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    q_push   = 1'b0;
    case (state_r)
      itdt_pkg::FE_IDLE: in_stall = 1'b0;
      itdt_pkg::FE_CONV: in_stall = 1'b1;
      itdt_pkg::FE_DONE: begin
        in_stall = q_status.full;
        q_push   = !q_status.full;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itdt_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= raw[W-1];
      mag_r <= itdt_pkg::PAD_WIDTH'(in_mag);
      bcd_r <= '0;
      cnt_r <= itdt_pkg::STEP_CNT_W'(itdt_pkg::STEPS - 1);
    end else if (state_r == itdt_pkg::FE_CONV) begin
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/itdt_queue.sv =====
// ---------------------------------------------------------------------------
// itdt_queue: two-entry queue between front and back
// Holds converted numbers so the front can convert while the back emits.
// ---------------------------------------------------------------------------
module itdt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_push,
  input  itdt_pkg::entry_t    q_wdata,
  input  logic                q_pop,
  output itdt_pkg::entry_t    q_rdata,
  output itdt_pkg::q_status_t q_status
);

  itdt_pkg::entry_t slots_r [itdt_pkg::QUEUE_DEPTH];

  logic                                      wr_ptr_r;
  logic                                      rd_ptr_r;
  logic [$clog2(itdt_pkg::QUEUE_DEPTH+1)-1:0] count_r;

  assign q_status.full  = (count_r == ($clog2(itdt_pkg::QUEUE_DEPTH+1))'(itdt_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign q_rdata        = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (q_push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({q_push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) slots_r[wr_ptr_r] <= q_wdata;
  end

endmodule

// ===== design/itdt_back.sv =====
// ---------------------------------------------------------------------------
// itdt_back: output side of integer_to_decimal_text
// Pops a converted number and emits the optional '-' and then its digits,
// most significant first, one character per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module itdt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  itdt_pkg::entry_t    q_data,
  input  itdt_pkg::q_status_t q_status,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          out_character,
  output logic                out_last
);

  itdt_pkg::bk_state_t state_r, state_nxt;

  logic [itdt_pkg::DIGITS-1:0][3:0]    digits_r;
  logic [itdt_pkg::DIGIT_IDX_W-1:0]    pos_r;
  logic                                finishing;
  itdt_pkg::bk_state_t                 load_state;

  // Load the next number in the cycle its predecessor's last digit leaves.
  assign finishing  = (state_r == itdt_pkg::BK_DIGIT) && (pos_r == '0) && !out_stall;
  assign q_pop      = !q_status.empty && ((state_r == itdt_pkg::BK_IDLE) || finishing);
  assign load_state = q_data.neg ? itdt_pkg::BK_SIGN : itdt_pkg::BK_DIGIT;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itdt_pkg::BK_IDLE: begin
        if (q_pop) state_nxt = load_state;
      end
      itdt_pkg::BK_SIGN: begin
        if (!out_stall) state_nxt = itdt_pkg::BK_DIGIT;
      end
      itdt_pkg::BK_DIGIT: begin
        if (finishing) state_nxt = q_pop ? load_state : itdt_pkg::BK_IDLE;
      end
      default: state_nxt = itdt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid     = 1'b0;
    out_character = itdt_pkg::CH_ZERO;
    out_last      = 1'b0;
    case (state_r)
      itdt_pkg::BK_IDLE: out_valid = 1'b0;
      itdt_pkg::BK_SIGN: begin
        out_valid     = 1'b1;
        out_character = itdt_pkg::CH_MINUS;
      end
      itdt_pkg::BK_DIGIT: begin
        out_valid     = 1'b1;
        out_character = itdt_pkg::CH_ZERO + {3'b000, digits_r[pos_r]};
        out_last      = (pos_r == '0);
      end
      default: out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itdt_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      digits_r <= q_data.digits;
      pos_r    <= q_data.top;
    end else if ((state_r == itdt_pkg::BK_DIGIT) && !out_stall) begin
      pos_r <= pos_r - 1'b1;
    end
  end

endmodule

// ===== design/integer_to_decimal_text.sv =====
// ---------------------------------------------------------------------------
// integer_to_decimal_text: signed integer to decimal ASCII text
// Channel  Dir  Ports                              Per item
// in       in   in_valid/in_stall, in_value        one signed value
// out      out  out_valid/out_stall, out_character one character, last flags
//               out_last                           the end of a number
//
// The front takes a value and runs a shift-add-3 BCD conversion of STEPS
// steps (8 at 32 bits), four bits a cycle, taking no new value meanwhile;
// in FE_DONE it pushes to a two-entry queue and may take the next value. The
// back emits one character per cycle while out_stall is low, 1 to 11 per
// number, back to back across numbers. Sustained rate is set by the slower
// side. Synchronous active-low reset empties the queue and idles both state
// machines. Each side stalls only on its own neighbor.
// ---------------------------------------------------------------------------
module integer_to_decimal_text (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [itdt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [6:0]                              out_character,
  output logic                                    out_last
);

  logic                q_push;
  logic                q_pop;
  itdt_pkg::entry_t    q_wdata;
  itdt_pkg::entry_t    q_rdata;
  itdt_pkg::q_status_t q_status;

  itdt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_status (q_status)
  );

  itdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_pop    (q_pop),
    .q_rdata  (q_rdata),
    .q_status (q_status)
  );

  itdt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_rdata),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == itdt_pkg::CH_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == itdt_pkg::CH_MINUS) ||
                  ((out_character >= itdt_pkg::CH_ZERO) &&
                   (out_character <= itdt_pkg::CH_ZERO + 7'd9)))
    else $error("character is neither minus nor digit");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_character == itdt_pkg::CH_MINUS) |=>
      (out_valid && out_character != itdt_pkg::CH_MINUS))
    else $error("minus sign not followed by a digit");

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: integer_to_decimal_text
// Sends signed 32-bit values and checks the decimal ASCII text that comes
// back, one character per item, against a local formatter. Covers the
// extremes, zero, single digits, each digit count and random values. Input
// gaps are random, output stalls random or periodic, some stretches neither.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_char_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  logic                                    clk;
  logic                                    rst_n = 1'b0;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  logic signed [itdt_pkg::VALUE_WIDTH-1:0] in_value = '0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  logic [6:0]                              out_character;
  logic                                    out_last;

  text_char_t  pending_chars[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_max = 4;
  stall_mode_t stall_mode = STALL_NONE;

  integer_to_decimal_text i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 99) < 40);
      end
      STALL_PERIODIC: begin
        out_stall <= ((cycle_count % 9) < 4);
      end
      default: begin
        out_stall <= 1'b0;
      end
    endcase
  end

  // Append the expected text of one value, sign first, digits most
  // significant first. Magnitude is one bit wider so the most negative fits.
  function automatic void format_decimal(
    input logic signed [itdt_pkg::VALUE_WIDTH-1:0] v
  );
    logic [itdt_pkg::VALUE_WIDTH:0] mag;
    logic [3:0]                     digs[$];
    text_char_t                     c;
    mag = v[itdt_pkg::VALUE_WIDTH-1] ?
            ({(itdt_pkg::VALUE_WIDTH+1){1'b0}} - {v[itdt_pkg::VALUE_WIDTH-1], v})
          : {1'b0, v};
    do begin
      digs.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[itdt_pkg::VALUE_WIDTH-1]) begin
      c.character = itdt_pkg::CH_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = 0; i < digs.size(); i++) begin
      c.character = itdt_pkg::CH_ZERO + 7'(digs[i]);
      c.last = (i == digs.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Compare each accepted character with the oldest expected one
  always @(negedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected item: character %0d last %0b", out_character, out_last);
        error_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_character !== exp_c.character) begin
          $error("character: expected %0d, actual %0d", exp_c.character, out_character);
          error_count++;
        end
        if (out_last !== exp_c.last) begin
          $error("last: expected %0b, actual %0b", exp_c.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Send one value, with a random gap at the start of each burst
  task automatic send_value(input logic signed [itdt_pkg::VALUE_WIDTH-1:0] v);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= v;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    format_decimal(v);
  endtask

  task automatic wait_text_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [itdt_pkg::VALUE_WIDTH-1:0] vals[$];
    vals = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
             32'sh7fffffff, 32'sh80000000, 32'sh80000001, 32'sd1000000000,
             -32'sd999999999, 32'sd12345, -32'sd5, 32'sd7};
    stall_mode = STALL_NONE;
    gap_max = 0;
    foreach (vals[i]) send_value(vals[i]);
    wait_text_drained();
  endtask

  // Random magnitude with a random digit count, so short texts are common
  task automatic test_digit_counts(input int count);
    longint unsigned span;
    longint unsigned mag;
    int n;
    bit neg;
    stall_mode = STALL_RANDOM;
    gap_max = 6;
    repeat (count) begin
      n = $urandom_range(1, 10);
      span = 1;
      repeat (n) span *= 10;
      mag = {$urandom(), $urandom()} % span;
      neg = 1'($urandom_range(0, 1));
      if (neg && mag > 64'd2147483648) mag = 64'd2147483648;
      if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
      send_value(neg ? (32'd0 - mag[31:0]) : mag[31:0]);
    end
  endtask

  // Full-range values; hold off until everything has drained halfway through
  task automatic test_full_range(input int count);
    stall_mode = STALL_PERIODIC;
    gap_max = 12;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_text_drained();
      send_value($urandom());
    end
  endtask

  task automatic test_back_to_back(input int count);
    stall_mode = STALL_NONE;
    gap_max = 0;
    repeat (count) begin
      send_value($urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_digit_counts(44);
    test_full_range(40);
    test_back_to_back(30);
    wait_text_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/itdt_pkg.sv
design/itdt_front.sv
design/itdt_queue.sv
design/itdt_back.sv
design/integer_to_decimal_text.sv
sim/testbench.sv
